/* src/alle_pkg.sv */
// shared types and constants for the array linked list engine
`timescale 1ns / 1ps

package alle_pkg;

    // table geometry
    localparam int DEPTH   = 16;
    localparam int SLOT_W  = 4;
    localparam int LINK_W  = 5;
    localparam int CNT_W   = 5;
    localparam int MAX_RES = 16;
    localparam int WCNT_W  = 4;
    localparam int DATA_W  = 64;

    // end of list marker held in a link
    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(DEPTH);

    // operation codes
    typedef enum logic [2:0] {
        OP_ADD_FIRST = 3'd0,
        OP_ADD_AFTER = 3'd1,
        OP_ADD_LAST  = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_AFTER = 3'd4,
        OP_DEL_LAST  = 3'd5,
        OP_DEL_ALL   = 3'd6,
        OP_WALK      = 3'd7
    } alle_op_t;

    // status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } alle_status_t;

    // command beat
    typedef struct packed {
        alle_op_t            operation;
        logic [SLOT_W-1:0]   prev_slot;
        logic [DATA_W-1:0]   item_code;
        logic [DATA_W-1:0]   item_name;
    } alle_cmd_t;

    // result beat
    typedef struct packed {
        alle_status_t        status;
        logic [SLOT_W-1:0]   slot;
        logic [CNT_W-1:0]    entry_count;
        logic [DATA_W-1:0]   out_code;
        logic [DATA_W-1:0]   out_name;
        logic                last;
    } alle_rsp_t;

endpackage

/* src/array_linked_list_engine.sv */
// array linked list engine: sequencer, link table and payload store
`timescale 1ns / 1ps

// Keeps one singly linked list in a table of 16 slots.
// Command channel: a beat on cmd is taken at a rising edge with start high
// and busy low; busy then stays high until the final result is shown.
// Result channel: each result sits on result for one cycle with done high;
// the receiver cannot stall, so every result must be taken when shown.
// The final result of a command has last set; busy is already low in that
// cycle, so the next start may be taken at the edge that ends it.
// Steps of each command; the sequencer visits one slot per cycle in its
// tail, free-slot and delete-last scans:
//   delete all, errors: check only
//   delete first, delete after: check, unlink
//   add first / add after: check, scan for the lowest free slot, link
//   add last: check, scan to the tail if not empty, free slot scan, link
//   delete last: check, scan for the slot before the tail, unlink
//   walk: check, then one entry per cycle in list order, 16 at most
// Reset empties the list and frees every slot at once; no clearing pass.
// Code and name entries are written only when a slot is added; links also on unlink.
module array_linked_list_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  alle_pkg::alle_cmd_t cmd,
    output logic               busy,
    output logic               done,
    output alle_pkg::alle_rsp_t result
);
    import alle_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_TAIL  = 8'b0000_0100,
        S_FREE  = 8'b0000_1000,
        S_LINK  = 8'b0001_0000,
        S_UNLNK = 8'b0010_0000,
        S_DSCAN = 8'b0100_0000,
        S_WALK  = 8'b1000_0000
    } state_t;

    // control registers
    state_t              state_reg, state_next;
    alle_op_t            op_reg, op_next;
    logic [SLOT_W-1:0]   prev_reg, prev_next;
    logic [DATA_W-1:0]   code_reg, code_next;
    logic [DATA_W-1:0]   name_reg, name_next;
    logic [LINK_W-1:0]   ptr_reg, ptr_next;
    logic [LINK_W-1:0]   pred_reg, pred_next;
    logic [SLOT_W-1:0]   scan_reg, scan_next;
    logic [SLOT_W-1:0]   free_reg, free_next;
    logic [WCNT_W-1:0]   wcnt_reg, wcnt_next;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DEPTH-1:0]    used_reg, used_next;
    logic                done_reg, done_next;
    alle_rsp_t           rsp_reg, rsp_next;

    // storage
    logic [LINK_W-1:0]   link_mem [DEPTH];
    logic [DATA_W-1:0]   code_mem [DEPTH];
    logic [DATA_W-1:0]   name_mem [DEPTH];

    // registered read data at the slot ptr points to
    logic [LINK_W-1:0]   link_rd_reg;
    logic [DATA_W-1:0]   code_rd_reg;
    logic [DATA_W-1:0]   name_rd_reg;

    // table write controls
    logic                lk_we_a, lk_we_b, pl_we;
    logic [SLOT_W-1:0]   lk_addr_a, lk_addr_b;
    logic [LINK_W-1:0]   lk_data_a, lk_data_b;

    logic [LINK_W-1:0]   nxt;
    logic                empty, full, prev_ok;

    // shared link read port
    assign nxt     = link_rd_reg;
    assign empty   = (head_reg == END_MARK);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign prev_ok = used_reg[prev_reg];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        prev_next  = prev_reg;
        code_next  = code_reg;
        name_next  = name_reg;
        ptr_next   = ptr_reg;
        pred_next  = pred_reg;
        scan_next  = scan_reg;
        free_next  = free_reg;
        wcnt_next  = wcnt_reg;
        head_next  = head_reg;
        count_next = count_reg;
        used_next  = used_reg;
        done_next  = 1'b0;
        rsp_next   = '0;
        lk_we_a    = 1'b0;
        lk_we_b    = 1'b0;
        pl_we      = 1'b0;
        lk_addr_a  = free_reg;
        lk_addr_b  = pred_reg[SLOT_W-1:0];
        lk_data_a  = nxt;
        lk_data_b  = nxt;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = cmd.operation;
                    prev_next  = cmd.prev_slot;
                    code_next  = cmd.item_code;
                    name_next  = cmd.item_name;
                    scan_next  = '0;
                    ptr_next   = (cmd.operation == OP_DEL_AFTER) ?
                                 {1'b0, cmd.prev_slot} : head_reg;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                case (op_reg)
                    OP_ADD_FIRST, OP_ADD_LAST:
                    begin
                        if (full)
                        begin
                            rsp_next.status = ST_FULL;
                            done_next       = 1'b1;
                        end
                        else if (op_reg == OP_ADD_LAST && !empty)
                            state_next = S_TAIL;
                        else
                        begin
                            pred_next  = END_MARK;
                            state_next = S_FREE;
                        end
                    end
                    OP_ADD_AFTER:
                    begin
                        if (full)
                        begin
                            rsp_next.status = ST_FULL;
                            done_next       = 1'b1;
                        end
                        else if (!prev_ok)
                        begin
                            rsp_next.status = ST_BAD;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            pred_next  = {1'b0, prev_reg};
                            state_next = S_FREE;
                        end
                    end
                    OP_DEL_FIRST:
                    begin
                        if (empty)
                        begin
                            rsp_next.status = ST_EMPTY;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            pred_next  = END_MARK;
                            state_next = S_UNLNK;
                        end
                    end
                    OP_DEL_AFTER:
                    begin
                        if (empty)
                        begin
                            rsp_next.status = ST_EMPTY;
                            done_next       = 1'b1;
                        end
                        else if (!prev_ok || nxt == END_MARK)
                        begin
                            rsp_next.status = ST_BAD;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            pred_next  = ptr_reg;
                            ptr_next   = nxt;
                            state_next = S_UNLNK;
                        end
                    end
                    OP_DEL_LAST:
                    begin
                        if (empty)
                        begin
                            rsp_next.status = ST_EMPTY;
                            done_next       = 1'b1;
                        end
                        else if (nxt == END_MARK)
                        begin
                            pred_next  = END_MARK;
                            state_next = S_UNLNK;
                        end
                        else
                        begin
                            pred_next  = ptr_reg;
                            ptr_next   = nxt;
                            state_next = S_DSCAN;
                        end
                    end
                    OP_DEL_ALL:
                    begin
                        used_next  = '0;
                        head_next  = END_MARK;
                        count_next = '0;
                        done_next  = 1'b1;
                    end
                    OP_WALK:
                    begin
                        if (empty)
                        begin
                            rsp_next.status = ST_EMPTY;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            wcnt_next  = '0;
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
                if (done_next)
                begin
                    rsp_next.last = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            // follow links to the tail for add last
            S_TAIL:
            begin
                if (nxt == END_MARK)
                begin
                    pred_next  = ptr_reg;
                    state_next = S_FREE;
                end
                else
                    ptr_next = nxt;
            end

            // lowest free slot, one slot per cycle
            S_FREE:
            begin
                if (!used_reg[scan_reg])
                begin
                    free_next  = scan_reg;
                    ptr_next   = pred_reg;
                    state_next = S_LINK;
                end
                else
                    scan_next = scan_reg + 1'b1;
            end

            // splice the new slot in after pred, or at the head
            S_LINK:
            begin
                lk_we_a   = 1'b1;
                lk_addr_a = free_reg;
                pl_we     = 1'b1;
                if (pred_reg == END_MARK)
                begin
                    lk_data_a = head_reg;
                    head_next = {1'b0, free_reg};
                end
                else
                begin
                    lk_data_a = nxt;
                    lk_we_b   = 1'b1;
                    lk_data_b = {1'b0, free_reg};
                end
                used_next[free_reg] = 1'b1;
                count_next          = count_reg + 1'b1;
                rsp_next.slot       = free_reg;
                rsp_next.last       = 1'b1;
                done_next           = 1'b1;
                state_next          = S_IDLE;
            end

            // find the slot before the tail for delete last
            S_DSCAN:
            begin
                if (nxt == END_MARK)
                    state_next = S_UNLNK;
                else
                begin
                    pred_next = ptr_reg;
                    ptr_next  = nxt;
                end
            end

            // drop the slot at ptr, pred is its predecessor or the head
            S_UNLNK:
            begin
                if (pred_reg == END_MARK)
                    head_next = nxt;
                else
                begin
                    lk_we_b   = 1'b1;
                    lk_data_b = nxt;
                end
                used_next[ptr_reg[SLOT_W-1:0]] = 1'b0;
                count_next    = count_reg - 1'b1;
                rsp_next.slot = ptr_reg[SLOT_W-1:0];
                rsp_next.last = 1'b1;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end

            // one entry per cycle in list order
            S_WALK:
            begin
                rsp_next.slot     = ptr_reg[SLOT_W-1:0];
                rsp_next.out_code = code_rd_reg;
                rsp_next.out_name = name_rd_reg;
                rsp_next.last     = (nxt == END_MARK) ||
                                    (wcnt_reg == WCNT_W'(MAX_RES - 1));
                done_next         = 1'b1;
                if (rsp_next.last)
                    state_next = S_IDLE;
                else
                begin
                    ptr_next  = nxt;
                    wcnt_next = wcnt_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_next.entry_count = count_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= END_MARK;
            count_reg <= '0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
            ptr_reg   <= '0;
            pred_reg  <= '0;
            scan_reg  <= '0;
            wcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
            ptr_reg   <= ptr_next;
            pred_reg  <= pred_next;
            scan_reg  <= scan_next;
            wcnt_reg  <= wcnt_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        prev_reg <= prev_next;
        code_reg <= code_next;
        name_reg <= name_next;
        free_reg <= free_next;
        rsp_reg  <= rsp_next;
    end

    // link table and payload store, read at the slot ptr moves to
    always_ff @(posedge clk)
    begin
        if (lk_we_a)
            link_mem[lk_addr_a] <= lk_data_a;
        if (lk_we_b)
            link_mem[lk_addr_b] <= lk_data_b;
        if (pl_we)
        begin
            code_mem[free_reg] <= code_reg;
            name_mem[free_reg] <= name_reg;
        end
        link_rd_reg <= link_mem[ptr_next[SLOT_W-1:0]];
        code_rd_reg <= code_mem[ptr_next[SLOT_W-1:0]];
        name_rd_reg <= name_mem[ptr_next[SLOT_W-1:0]];
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

/* src/alle_checker.sv */
// port-level checker for the array linked list engine, with its bind
`timescale 1ns / 1ps

module alle_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input alle_pkg::alle_cmd_t cmd,
    input logic                busy,
    input logic                done,
    input alle_pkg::alle_rsp_t result
);
    import alle_pkg::*;

    // an accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // the final result frees the block in the same cycle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.last |-> !busy)
        else $error("busy still high on final result");

    // more results pending keeps the block busy
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.last |-> busy)
        else $error("busy low while results remain");

    // an error result is always the only one
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.last && result.slot == '0)
        else $error("error result not final");

    // no result appears while idle with no work taken
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !done |=> !done)
        else $error("result without a command");

endmodule

bind array_linked_list_engine alle_checker u_alle_checker (.*);

/* tb/sv/array_linked_list_engine_test.sv */
// self-checking testbench for the array linked list engine
`timescale 1ns / 1ps

module array_linked_list_engine_test;

    import alle_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 48;
    localparam int REPORT_LIMIT  = 10;

    logic      clk;
    logic      rst_n;
    logic      start;
    alle_cmd_t cmd;
    logic      busy;
    logic      done;
    alle_rsp_t result;

    array_linked_list_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // list image kept by the testbench, indices as ints, DEPTH is the end marker
    bit              slot_taken [DEPTH];
    int              link_of    [DEPTH];
    logic [DATA_W-1:0] code_of  [DEPTH];
    logic [DATA_W-1:0] name_of  [DEPTH];
    int              head_slot = DEPTH;
    int              live_cnt  = 0;

    alle_rsp_t awaited_rsp [$];
    int        error_count = 0;
    int        idle_pct    = 0;
    int        cycle_count = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // list image helpers
    function automatic int first_free_slot();
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!slot_taken[i])
                return i;
        end
        return DEPTH;
    endfunction

    function automatic int tail_of_list();
        int t;
        t = head_slot;
        while (link_of[t] != DEPTH)
            t = link_of[t];
        return t;
    endfunction

    function automatic int unlink_after(int pred);
        int v;
        v = link_of[pred];
        link_of[pred] = link_of[v];
        slot_taken[v] = 1'b0;
        live_cnt--;
        return v;
    endfunction

    function automatic int unlink_head();
        int h;
        h = head_slot;
        head_slot = link_of[h];
        slot_taken[h] = 1'b0;
        live_cnt--;
        return h;
    endfunction

    // apply one accepted command to the list image and queue the results it yields
    function automatic void apply_list_command(alle_cmd_t c);
        alle_rsp_t r;
        int        s;
        int        p;
        int        k;
        bit        prev_ok;
        r       = '0;
        r.last  = 1'b1;
        prev_ok = slot_taken[c.prev_slot];
        case (c.operation)
            OP_ADD_FIRST, OP_ADD_LAST, OP_ADD_AFTER:
            begin
                if (live_cnt >= DEPTH)
                    r.status = ST_FULL;
                else if (c.operation == OP_ADD_AFTER && !prev_ok)
                    r.status = ST_BAD;
                else
                begin
                    if (c.operation == OP_ADD_AFTER)
                        p = c.prev_slot;
                    else if (c.operation == OP_ADD_LAST && head_slot != DEPTH)
                        p = tail_of_list();
                    else
                        p = DEPTH;
                    s = first_free_slot();
                    slot_taken[s] = 1'b1;
                    code_of[s]    = c.item_code;
                    name_of[s]    = c.item_name;
                    if (p == DEPTH)
                    begin
                        link_of[s] = head_slot;
                        head_slot  = s;
                    end
                    else
                    begin
                        link_of[s] = link_of[p];
                        link_of[p] = s;
                    end
                    live_cnt++;
                    r.slot = SLOT_W'(s);
                end
            end
            OP_DEL_FIRST:
            begin
                if (head_slot == DEPTH)
                    r.status = ST_EMPTY;
                else
                    r.slot = SLOT_W'(unlink_head());
            end
            OP_DEL_AFTER:
            begin
                if (head_slot == DEPTH)
                    r.status = ST_EMPTY;
                else if (!prev_ok || link_of[c.prev_slot] == DEPTH)
                    r.status = ST_BAD;
                else
                    r.slot = SLOT_W'(unlink_after(c.prev_slot));
            end
            OP_DEL_LAST:
            begin
                if (head_slot == DEPTH)
                    r.status = ST_EMPTY;
                else if (link_of[head_slot] == DEPTH)
                    r.slot = SLOT_W'(unlink_head());
                else
                begin
                    p = head_slot;
                    while (link_of[link_of[p]] != DEPTH)
                        p = link_of[p];
                    r.slot = SLOT_W'(unlink_after(p));
                end
            end
            OP_DEL_ALL:
            begin
                for (int i = 0; i < DEPTH; i++)
                    slot_taken[i] = 1'b0;
                head_slot = DEPTH;
                live_cnt  = 0;
            end
            default:
            begin
                if (head_slot == DEPTH)
                    r.status = ST_EMPTY;
                else
                begin
                    // one beat per entry in list order, capped at MAX_RES
                    s = head_slot;
                    k = 0;
                    while (s != DEPTH && k < MAX_RES)
                    begin
                        r.slot        = SLOT_W'(s);
                        r.entry_count = CNT_W'(live_cnt);
                        r.out_code    = code_of[s];
                        r.out_name    = name_of[s];
                        r.last        = (link_of[s] == DEPTH) || (k == MAX_RES - 1);
                        awaited_rsp.push_back(r);
                        if (r.last)
                            break;
                        s = link_of[s];
                        k++;
                    end
                    return;
                end
            end
        endcase
        r.entry_count = CNT_W'(live_cnt);
        awaited_rsp.push_back(r);
    endfunction

    // stimulus helpers
    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic alle_cmd_t make_cmd(alle_op_t op, logic [SLOT_W-1:0] prev,
                                           logic [DATA_W-1:0] code,
                                           logic [DATA_W-1:0] name);
        alle_cmd_t c;
        c.operation = op;
        c.prev_slot = prev;
        c.item_code = code;
        c.item_name = name;
        return c;
    endfunction

    // mostly a slot that is in the list, otherwise any index
    function automatic logic [SLOT_W-1:0] pick_prev(int live_pct);
        int taken [$];
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_taken[i])
                taken.push_back(i);
        end
        if (taken.size() != 0 && $urandom_range(99) < live_pct)
            return SLOT_W'(taken[$urandom_range(taken.size() - 1)]);
        return SLOT_W'($urandom_range(DEPTH - 1));
    endfunction

    function automatic alle_op_t pick_random_op(bit growing);
        int r;
        r = $urandom_range(99);
        if (growing)
        begin
            if (r < 28) return OP_ADD_LAST;
            if (r < 48) return OP_ADD_FIRST;
            if (r < 70) return OP_ADD_AFTER;
            if (r < 78) return OP_DEL_FIRST;
            if (r < 84) return OP_DEL_AFTER;
            if (r < 88) return OP_DEL_LAST;
            if (r < 99) return OP_WALK;
            return OP_DEL_ALL;
        end
        if (r < 10) return OP_ADD_FIRST;
        if (r < 20) return OP_ADD_AFTER;
        if (r < 25) return OP_ADD_LAST;
        if (r < 45) return OP_DEL_FIRST;
        if (r < 65) return OP_DEL_AFTER;
        if (r < 82) return OP_DEL_LAST;
        if (r < 96) return OP_WALK;
        return OP_DEL_ALL;
    endfunction

    // send one command beat, predict on accept, then idle at random
    task automatic send_command(input alle_cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        apply_list_command(c);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    // walk, the three single deletes and add after on an empty list
    task automatic test_empty_list();
        send_command(make_cmd(OP_WALK,      4'h0, '0, '0));
        send_command(make_cmd(OP_DEL_FIRST, 4'h0, '0, '0));
        send_command(make_cmd(OP_DEL_AFTER, 4'hF, '1, '1));
        send_command(make_cmd(OP_DEL_LAST,  4'h0, '0, '0));
        send_command(make_cmd(OP_ADD_AFTER, 4'h0, '1, '1));
    endtask

    // fill all slots with a mix of add kinds and extreme payloads
    task automatic test_fill_to_full();
        alle_op_t          op;
        logic [DATA_W-1:0] code;
        logic [DATA_W-1:0] name;
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i % 3)
                0:       op = OP_ADD_FIRST;
                1:       op = OP_ADD_LAST;
                default: op = OP_ADD_AFTER;
            endcase
            case (i % 4)
                0:       begin code = '1; name = '0; end
                1:       begin code = '0; name = '1; end
                2:       begin code = {32{2'b10}}; name = {32{2'b01}}; end
                default: begin code = rand_word(); name = rand_word(); end
            endcase
            send_command(make_cmd(op, pick_prev(100), code, name));
        end
    endtask

    // full table, long walk, the delete corner cases, add last on an empty list
    task automatic test_full_and_deletes();
        send_command(make_cmd(OP_ADD_FIRST, 4'h0, rand_word(), rand_word()));
        send_command(make_cmd(OP_ADD_AFTER, 4'hF, rand_word(), rand_word()));
        send_command(make_cmd(OP_ADD_LAST,  4'h0, rand_word(), rand_word()));
        send_command(make_cmd(OP_WALK,      4'h0, '0, '0));
        send_command(make_cmd(OP_DEL_AFTER, SLOT_W'(tail_of_list()), '0, '0));
        send_command(make_cmd(OP_DEL_AFTER, SLOT_W'(head_slot), '0, '0));
        send_command(make_cmd(OP_DEL_LAST,  4'h0, '0, '0));
        // the old head becomes a free slot as predecessor
        begin
            logic [SLOT_W-1:0] old_head;
            old_head = SLOT_W'(head_slot);
            send_command(make_cmd(OP_DEL_FIRST, 4'h0, '0, '0));
            send_command(make_cmd(OP_DEL_AFTER, old_head, '0, '0));
        end
        send_command(make_cmd(OP_ADD_AFTER, SLOT_W'(head_slot), '1, '1));
        send_command(make_cmd(OP_WALK,      4'h0, '0, '0));
        send_command(make_cmd(OP_DEL_ALL,   4'h0, '0, '0));
        send_command(make_cmd(OP_ADD_LAST,  4'h5, rand_word(), rand_word()));
        send_command(make_cmd(OP_DEL_LAST,  4'h0, '0, '0));
    endtask

    // random traffic, alternating growing and shrinking stretches
    task automatic test_random_traffic(input int n_items, input int pct);
        alle_op_t op;
        idle_pct = pct;
        for (int i = 0; i < n_items; i++)
        begin
            op = pick_random_op(((i / 28) % 2) == 0);
            send_command(make_cmd(op, pick_prev(85), rand_word(), rand_word()));
        end
    endtask

    // log one failing result beat
    task automatic log_mismatch(input string why, input alle_rsp_t want,
                                input alle_rsp_t got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("%0t %s: expected st=%0d slot=%0d cnt=%0d code=%h name=%h last=%b",
                     $realtime, why, want.status, want.slot, want.entry_count,
                     want.out_code, want.out_name, want.last);
            $display("        got      st=%0d slot=%0d cnt=%0d code=%h name=%h last=%b",
                     got.status, got.slot, got.entry_count,
                     got.out_code, got.out_name, got.last);
        end
    endtask

    // result checker, one beat per strobe
    initial
    begin : result_checker
        alle_rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && done)
            begin
                if (awaited_rsp.size() == 0)
                    log_mismatch("unexpected result", '0, result);
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (result.status      !== want.status      ||
                        result.slot        !== want.slot        ||
                        result.entry_count !== want.entry_count ||
                        result.out_code    !== want.out_code    ||
                        result.out_name    !== want.out_name    ||
                        result.last        !== want.last)
                        log_mismatch("result mismatch", want, result);
                end
            end
        end
    end

    // run limit
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 0;
        test_empty_list();
        test_fill_to_full();
        test_full_and_deletes();

        test_random_traffic(72, 0);
        test_random_traffic(72, 50);
        test_random_traffic(72, 30);

        start <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
